@@ design/aabb_ct_pkg.sv @@
package aabb_ct_pkg;

    // stream payload widths
    localparam int unsigned S_TDATA_W = 80;   // 78 bits of fields, padded to bytes
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 3;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned SIZE_W = 15;
    localparam int unsigned EDGE_W = 18;      // wide enough for pos + size without overflow

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_DUP       = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        [ID_W-1:0]   handle;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic        [SIZE_W-1:0] size_x;
        logic        [SIZE_W-1:0] size_y;
    } t_entry;

    // per-cell control
    typedef struct packed {
        logic shift;   // take neighbor's entry
        logic load;    // take the new entry
    } t_cell_ctl;

    // head compare result
    typedef struct packed {
        logic same_id;
        logic overlap;
    } t_match;

endpackage

@@ design/aabb_ct_cell.sv @@
module aabb_ct_cell (
    input  logic                  i_clk,
    input  aabb_ct_pkg::t_cell_ctl i_ctl,
    input  aabb_ct_pkg::t_entry   i_next,
    input  aabb_ct_pkg::t_entry   i_load_entry,
    output aabb_ct_pkg::t_entry   o_entry
);
    import aabb_ct_pkg::*;

    t_entry r_entry;

    // payload only, contents are meaningless above the fill count
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_entry;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ design/aabb_ct_match.sv @@
module aabb_ct_match (
    input  aabb_ct_pkg::t_entry i_query,
    input  aabb_ct_pkg::t_entry i_head,
    output aabb_ct_pkg::t_match o_match
);
    import aabb_ct_pkg::*;

    logic signed [EDGE_W-1:0] q_left, q_right, q_top, q_bottom;
    logic signed [EDGE_W-1:0] h_left, h_right, h_top, h_bottom;

    always_comb begin
        q_left   = EDGE_W'(i_query.pos_x);
        q_top    = EDGE_W'(i_query.pos_y);
        q_right  = q_left + $signed({3'b000, i_query.size_x});
        q_bottom = q_top  + $signed({3'b000, i_query.size_y});
        h_left   = EDGE_W'(i_head.pos_x);
        h_top    = EDGE_W'(i_head.pos_y);
        h_right  = h_left + $signed({3'b000, i_head.size_x});
        h_bottom = h_top  + $signed({3'b000, i_head.size_y});

        o_match.same_id = (i_query.handle == i_head.handle);
        // strict overlap on both axes
        o_match.overlap = (q_left < h_right) && (q_right > h_left) &&
                          (q_top < h_bottom) && (q_bottom > h_top);
    end

endmodule

@@ design/aabb_collision_table_unit.sv @@
// Sequence: a request is taken in IDLE, the ring of cells rotates once past the head comparator
//   in SCAN, SCAN then sees the scan end and a FINISH state writes the final result.
// A new request is taken only after the previous one has finished and the unit is back in IDLE;
//   output back-pressure stalls the ring rotation and the FINISH state.
// A check hit is held until the next hit or the end of the scan shows whether it is last.
// Reset: synchronous active-low; clears control, fill count and output valid; entries keep data.
module aabb_collision_table_unit #(
    parameter int unsigned TABLE_DEPTH = 32   // 1..64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request: opcode in tuser
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [15:0] collider_id, [31:16] pos_x, [47:32] pos_y, [62:48] size_x,
    // [77:63] size_y, [79:78] zero
    input  logic [aabb_ct_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [1:0] opcode
    input  logic [aabb_ct_pkg::S_TUSER_W-1:0]    i_s_tuser,
    // results
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [15:0] hit_id
    output logic [aabb_ct_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [1:0] status, [2] hit_valid
    output logic [aabb_ct_pkg::M_TUSER_W-1:0]    o_m_tuser,
    output logic                                 o_m_tlast
);
    import aabb_ct_pkg::*;

    localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state          r_state, n_state;
    t_opcode         r_op;
    t_entry          r_query;
    logic [CNTW-1:0] r_step;     // head index during rotation
    logic [CNTW-1:0] r_count;    // number of valid entries
    logic            r_found;    // handle seen (add / remove)
    logic [CNTW-1:0] r_loc;      // index of the first matching handle
    logic            r_pend_valid;
    logic [ID_W-1:0] r_pend_id;  // latest hit, held until we know if it is last

    logic            r_out_valid;
    t_status         r_out_status;
    logic            r_out_hit;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_last;

    // ------------------------------------------------------------------
    // Cell chain: cell k takes cell k+1, the head (cell 0) wraps to the tail.
    // Full rotation for scans, partial shift (k >= loc) closes a gap on remove.
    // ------------------------------------------------------------------
    t_entry    entries [TABLE_DEPTH];
    t_match    head_match;

    logic      rot_all;
    logic      compact;
    logic      do_load;

    generate
        for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            t_cell_ctl cell_ctl;
            always_comb begin
                cell_ctl.shift = rot_all || (compact && (CNTW'(k) >= r_loc));
                cell_ctl.load  = do_load && (r_count == CNTW'(k));
            end
            aabb_ct_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_next       (entries[(k + 1) % TABLE_DEPTH]),
                .i_load_entry (r_query),
                .o_entry      (entries[k])
            );
        end
    endgenerate

    aabb_ct_match u_match (
        .i_query (r_query),
        .i_head  (entries[0]),
        .o_match (head_match)
    );

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic    s_accept;
    logic    out_free;
    logic    in_range;
    logic    hit_sel;
    logic    match_sel;
    logic    scan_done;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;
    assign in_range  = (r_step < r_count);
    assign scan_done = (r_step == DEPTH_C);
    assign hit_sel   = in_range && (r_op == OP_CHECK) && !head_match.same_id &&
                       head_match.overlap;
    assign match_sel = in_range && head_match.same_id && !r_found;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: ring control and result push
    // ------------------------------------------------------------------
    logic            advance;
    logic            push;
    t_status         push_status;
    logic            push_hit;
    logic [ID_W-1:0] push_id;
    logic            push_last;
    logic            count_inc;
    logic            count_dec;

    always_comb begin
        o_s_tready  = 1'b0;
        advance     = 1'b0;
        rot_all     = 1'b0;
        compact     = 1'b0;
        do_load     = 1'b0;
        push        = 1'b0;
        push_status = ST_DONE;
        push_hit    = 1'b0;
        push_id     = '0;
        push_last   = 1'b1;
        count_inc   = 1'b0;
        count_dec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_SCAN: begin
                // stall the ring while a result cannot be stored
                if (!scan_done && out_free) begin
                    advance = 1'b1;
                    rot_all = 1'b1;
                    // a new hit releases the previous one as not-last
                    if (hit_sel && r_pend_valid) begin
                        push      = 1'b1;
                        push_hit  = 1'b1;
                        push_id   = r_pend_id;
                        push_last = 1'b0;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    push = 1'b1;
                    case (r_op)
                        OP_ADD: begin
                            if (r_found) begin
                                push_status = ST_DUP;
                            end else if (r_count == DEPTH_C) begin
                                push_status = ST_FULL;
                            end else begin
                                do_load   = 1'b1;
                                count_inc = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (!r_found) begin
                                push_status = ST_NOT_FOUND;
                            end else begin
                                compact   = 1'b1;
                                count_dec = 1'b1;
                            end
                        end
                        OP_CHECK: begin
                            push_hit = r_pend_valid;
                            push_id  = r_pend_valid ? r_pend_id : '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_found      <= 1'b0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (s_accept) begin
                r_step       <= '0;
                r_found      <= 1'b0;
                r_pend_valid <= 1'b0;
            end else if (advance) begin
                r_step <= r_step + 1'b1;
                if (match_sel) r_found <= 1'b1;
                if (hit_sel) r_pend_valid <= 1'b1;
            end

            if (count_inc) begin
                r_count <= r_count + 1'b1;
            end else if (count_dec) begin
                r_count <= r_count - 1'b1;
            end

            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op           <= t_opcode'(i_s_tuser[1:0]);
            r_query.handle <= i_s_tdata[15:0];
            r_query.pos_x  <= $signed(i_s_tdata[31:16]);
            r_query.pos_y  <= $signed(i_s_tdata[47:32]);
            r_query.size_x <= i_s_tdata[62:48];
            r_query.size_y <= i_s_tdata[77:63];
        end
        if (advance && match_sel) r_loc <= r_step;
        if (advance && hit_sel) r_pend_id <= entries[0].handle;
        if (push) begin
            r_out_status <= push_status;
            r_out_hit    <= push_hit;
            r_out_id     <= push_id;
            r_out_last   <= push_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_id;
    assign o_m_tuser  = {r_out_hit, r_out_status};
    assign o_m_tlast  = r_out_last;

endmodule
